@@ hw/rtl/jsi_pkg.sv @@
`default_nettype none
package jsi_pkg;

    localparam int JOINTS_DEF = 6;
    localparam int MAX_JOINTS = 6;

    localparam int VAL_W   = 32;
    localparam int SEQ_W   = 32;
    localparam int MAG_W   = 31;
    localparam int MASK_W  = 6;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int SHIFT   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [MAG_W-1:0]         DEADBAND_RST    = '0;
    localparam logic signed [VAL_W-1:0]  SCALE_RST       = 32'sd65536;
    localparam logic [MAG_W-1:0]         MAX_STEP_RST    = 31'd65536;
    localparam logic [MASK_W-1:0]        NEGATE_MASK_RST = '0;

    typedef enum logic [1:0] {
        REQ_UPDATE = 2'd0,
        REQ_START  = 2'd1,
        REQ_CLEAR  = 2'd2
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEADBAND    = 2'd0,
        CFG_SCALE       = 2'd1,
        CFG_MAX_STEP    = 2'd2,
        CFG_NEGATE_MASK = 2'd3
    } cfg_idx_t;

    // what the session logic tells every target register
    typedef struct packed {
        logic load;
        logic clear;
        logic apply;
    } cmd_t;

    typedef struct packed {
        logic applied;
        logic consumed;
        logic cmpl_edge;
    } flags_t;

endpackage
`default_nettype wire

@@ hw/rtl/jsi_lane.sv @@
`default_nettype none
// Per-joint increment path: multiply and deadband compare, then floor shift, direction and clamp.
module jsi_lane (
    input  wire logic                                aclk,
    input  wire logic                                en1,
    input  wire logic                                en2,
    input  wire logic signed [jsi_pkg::VAL_W-1:0]    value,
    input  wire logic signed [jsi_pkg::VAL_W-1:0]    scale,
    input  wire logic [jsi_pkg::MAG_W-1:0]           deadband,
    input  wire logic [jsi_pkg::MAG_W-1:0]           max_step,
    input  wire logic                                negate,
    output logic signed [jsi_pkg::VAL_W-1:0]         value_s2,
    output logic signed [jsi_pkg::VAL_W-1:0]         step_s2,
    output logic                                     active_s2
);
    localparam int VW = jsi_pkg::VAL_W;
    localparam int PW = jsi_pkg::PROD_W;
    localparam int SW = PW - jsi_pkg::SHIFT + 1;

    logic signed [VW-1:0] value_reg;
    logic signed [PW-1:0] prod_reg;
    logic                 above_reg;
    logic signed [VW-1:0] step_reg;
    logic                 active_reg;
    logic signed [VW-1:0] value2_reg;

    logic [VW-1:0]        mag;
    logic signed [PW-1:0] prod_next;
    logic signed [SW-1:0] shifted;
    logic signed [SW-1:0] dir;
    logic signed [SW-1:0] lim;
    logic signed [SW-1:0] clamped;

    always_comb begin
        mag       = value[VW-1] ? (~value + 1'b1) : value;
        prod_next = value * scale;
        // arithmetic shift of the full product floors towards minus infinity
        shifted   = {prod_reg[PW-1], prod_reg[PW-1:jsi_pkg::SHIFT]};
        dir       = negate ? -shifted : shifted;
        lim       = $signed({{(SW-jsi_pkg::MAG_W){1'b0}}, max_step});
        if (dir > lim) begin
            clamped = lim;
        end else if (dir < -lim) begin
            clamped = -lim;
        end else begin
            clamped = dir;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            value_reg <= value;
            prod_reg  <= prod_next;
            above_reg <= mag > {1'b0, deadband};
        end
        if (en2) begin
            value2_reg <= value_reg;
            step_reg   <= clamped[VW-1:0];
            active_reg <= above_reg;
        end
    end

    assign value_s2  = value2_reg;
    assign step_s2   = step_reg;
    assign active_s2 = active_reg;

endmodule
`default_nettype wire

@@ hw/rtl/jsi_target.sv @@
`default_nettype none
// Target position of one joint: load, clear or saturating accumulate.
module jsi_target (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                en,
    input  wire jsi_pkg::cmd_t                       cmd,
    input  wire logic signed [jsi_pkg::VAL_W-1:0]    value,
    input  wire logic signed [jsi_pkg::VAL_W-1:0]    step,
    input  wire logic                                active,
    output logic signed [jsi_pkg::VAL_W-1:0]         target
);
    localparam int VW = jsi_pkg::VAL_W;

    logic signed [VW-1:0] target_reg;
    logic signed [VW-1:0] target_next;
    logic signed [VW:0]   sum;

    always_comb begin
        sum         = {target_reg[VW-1], target_reg} + {step[VW-1], step};
        target_next = target_reg;
        if (cmd.load) begin
            target_next = value;
        end else if (cmd.clear) begin
            target_next = '0;
        end else if (cmd.apply && active) begin
            if (sum[VW] != sum[VW-1]) begin
                target_next = sum[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
            end else begin
                target_next = sum[VW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
        end else if (en) begin
            target_reg <= target_next;
        end
    end

    assign target = target_reg;

endmodule
`default_nettype wire

@@ hw/rtl/jsi_ctrl.sv @@
`default_nettype none
// Session state and the gates of an update; one decision per step.
module jsi_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic [1:0]                    req_type,
    input  wire logic [jsi_pkg::SEQ_W-1:0]     sample_seq,
    input  wire logic [jsi_pkg::SEQ_W-1:0]     completion_seq,
    input  wire logic                          sample_valid,
    output jsi_pkg::cmd_t                      cmd,
    output jsi_pkg::flags_t                    flags
);
    logic                        active_reg;
    logic                        active_next;
    logic [jsi_pkg::SEQ_W-1:0]   last_seq_reg;
    logic [jsi_pkg::SEQ_W-1:0]   last_seq_next;
    logic [jsi_pkg::SEQ_W-1:0]   base_reg;
    logic [jsi_pkg::SEQ_W-1:0]   base_next;
    jsi_pkg::flags_t             flags_reg;
    jsi_pkg::flags_t             flags_next;

    always_comb begin
        active_next   = active_reg;
        last_seq_next = last_seq_reg;
        base_next     = base_reg;
        flags_next    = '0;
        cmd           = '0;
        case (req_type)
            jsi_pkg::REQ_START: begin
                cmd.load      = 1'b1;
                last_seq_next = sample_seq;
                base_next     = completion_seq;
                active_next   = 1'b1;
            end
            jsi_pkg::REQ_CLEAR: begin
                cmd.clear     = 1'b1;
                last_seq_next = '0;
                base_next     = '0;
                active_next   = 1'b0;
            end
            jsi_pkg::REQ_UPDATE: begin
                if (active_reg) begin
                    if (completion_seq > base_reg) begin
                        flags_next.cmpl_edge = 1'b1;
                    end else if (sample_seq != last_seq_reg) begin
                        last_seq_next       = sample_seq;
                        flags_next.consumed = 1'b1;
                        flags_next.applied  = sample_valid;
                        cmd.apply           = sample_valid;
                    end
                end
            end
            default: begin
            end
        endcase
        if (!en) begin
            cmd = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            last_seq_reg <= '0;
            base_reg     <= '0;
        end else if (en) begin
            active_reg   <= active_next;
            last_seq_reg <= last_seq_next;
            base_reg     <= base_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            flags_reg <= flags_next;
        end
    end

    assign flags = flags_reg;

endmodule
`default_nettype wire

@@ hw/rtl/jog_increment_setpoint_integrator_top.sv @@
`default_nettype none
// Jog setpoint integrator for up to six joints, signed Q16.16 throughout.
// One request is taken per cycle while the output is not stalled, and its result passes
// through a multiply stage, a shift/direction/clamp stage, then the session gates and
// the saturating target update, whose registers are also the result. Each
// joint lane has its own 32x32 multiplier; the stages stall together from
// the output back, and bubbles are squeezed out, so input and output keep
// moving at one transfer per cycle while the receiver is ready. The configuration port is always ready
// and must only be written while no request is in flight.
module jog_increment_setpoint_integrator_top #(
    parameter int JOINTS = jsi_pkg::JOINTS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [31:0] sample_seq, [63:32] completion_seq, [95:64] joint0_value ...
    // [255:224] joint5_value
    input  wire logic [255:0]                        s_tdata,
    // [1:0] req_type, [2] sample_valid
    input  wire logic [2:0]                          s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [31:0] target0 ... [191:160] target5
    output logic [191:0]                             m_tdata,
    // [0] completion_edge, [1] sample_taken, [2] incr_applied
    output logic [2:0]                               m_tuser,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [jsi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [jsi_pkg::CFG_DATA_W-1:0]      cfg_data
);
    localparam int VW = jsi_pkg::VAL_W;
    localparam int SQ = jsi_pkg::SEQ_W;

    logic [jsi_pkg::MAG_W-1:0]   deadband_reg;
    logic signed [VW-1:0]        scale_reg;
    logic [jsi_pkg::MAG_W-1:0]   max_step_reg;
    logic [jsi_pkg::MASK_W-1:0]  negate_mask_reg;

    logic v1_reg, v2_reg, out_valid_reg;
    logic ready1, ready2, ready3;
    logic en1, en2, en3;

    logic [1:0]    req1_reg, req2_reg;
    logic [SQ-1:0] sseq1_reg, sseq2_reg;
    logic [SQ-1:0] cseq1_reg, cseq2_reg;
    logic          svalid1_reg, svalid2_reg;

    jsi_pkg::cmd_t   cmd;
    jsi_pkg::flags_t flags;

    logic signed [VW-1:0] target [jsi_pkg::MAX_JOINTS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadband_reg    <= jsi_pkg::DEADBAND_RST;
            scale_reg       <= jsi_pkg::SCALE_RST;
            max_step_reg    <= jsi_pkg::MAX_STEP_RST;
            negate_mask_reg <= jsi_pkg::NEGATE_MASK_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                jsi_pkg::CFG_DEADBAND:    deadband_reg    <= cfg_data[jsi_pkg::MAG_W-1:0];
                jsi_pkg::CFG_SCALE:       scale_reg       <= $signed(cfg_data[VW-1:0]);
                jsi_pkg::CFG_MAX_STEP:    max_step_reg    <= cfg_data[jsi_pkg::MAG_W-1:0];
                jsi_pkg::CFG_NEGATE_MASK: negate_mask_reg <= cfg_data[jsi_pkg::MASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // a stage moves when it is empty or its successor moves
    assign ready3   = !out_valid_reg || m_tready;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign s_tready = ready1;
    assign en1      = s_tvalid && ready1;
    assign en2      = v1_reg && ready2;
    assign en3      = v2_reg && ready3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (ready1) begin
                v1_reg <= s_tvalid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
            if (ready3) begin
                out_valid_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            req1_reg    <= s_tuser[1:0];
            svalid1_reg <= s_tuser[2];
            sseq1_reg   <= s_tdata[SQ-1:0];
            cseq1_reg   <= s_tdata[2*SQ-1:SQ];
        end
        if (en2) begin
            req2_reg    <= req1_reg;
            svalid2_reg <= svalid1_reg;
            sseq2_reg   <= sseq1_reg;
            cseq2_reg   <= cseq1_reg;
        end
    end

    jsi_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (en3),
        .req_type       (req2_reg),
        .sample_seq     (sseq2_reg),
        .completion_seq (cseq2_reg),
        .sample_valid   (svalid2_reg),
        .cmd            (cmd),
        .flags          (flags)
    );

    for (genvar j = 0; j < jsi_pkg::MAX_JOINTS; j++) begin : g_joint
        if (j < JOINTS) begin : g_lane
            logic signed [VW-1:0] value_s2;
            logic signed [VW-1:0] step_s2;
            logic                 active_s2;

            jsi_lane u_lane (
                .aclk      (aclk),
                .en1       (en1),
                .en2       (en2),
                .value     ($signed(s_tdata[2*SQ+j*VW +: VW])),
                .scale     (scale_reg),
                .deadband  (deadband_reg),
                .max_step  (max_step_reg),
                .negate    (negate_mask_reg[j]),
                .value_s2  (value_s2),
                .step_s2   (step_s2),
                .active_s2 (active_s2)
            );

            jsi_target u_target (
                .aclk    (aclk),
                .aresetn (aresetn),
                .en      (en3),
                .cmd     (cmd),
                .value   (value_s2),
                .step    (step_s2),
                .active  (active_s2),
                .target  (target[j])
            );
        end else begin : g_unused
            assign target[j] = '0;
        end
        assign m_tdata[j*VW +: VW] = target[j];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {flags.applied, flags.consumed, flags.cmpl_edge};

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
module tb_top;

    localparam logic [1:0] REQ_UNUSED      = 2'd3;
    localparam int         RESET_CYCLES    = 9;
    localparam int         DRAIN_CYCLES    = 12;
    localparam int         HOLD_OFF_CYCLES = 200;
    localparam int         WATCHDOG_LIMIT  = 5000;
    localparam longint     TARGET_MAX      = 64'sd2147483647;
    localparam longint     TARGET_MIN      = -64'sd2147483648;

    typedef logic [jsi_pkg::MAX_JOINTS-1:0][jsi_pkg::VAL_W-1:0] joint_vec_t;

    typedef struct packed {
        joint_vec_t      targets;
        jsi_pkg::flags_t flags;
    } setpoint_result_t;

    class setpoint_scoreboard_t;
        logic [jsi_pkg::MAG_W-1:0]        deadband;
        logic signed [jsi_pkg::VAL_W-1:0] scale;
        logic [jsi_pkg::MAG_W-1:0]        max_step;
        logic [jsi_pkg::MASK_W-1:0]       negate_mask;
        longint                           target [jsi_pkg::MAX_JOINTS];
        logic [jsi_pkg::SEQ_W-1:0]        last_seq;
        logic [jsi_pkg::SEQ_W-1:0]        baseline;
        bit                               active;
        setpoint_result_t                 expected_q [$];
        int unsigned                      mismatches;

        function new();
            deadband    = jsi_pkg::DEADBAND_RST;
            scale       = jsi_pkg::SCALE_RST;
            max_step    = jsi_pkg::MAX_STEP_RST;
            negate_mask = jsi_pkg::NEGATE_MASK_RST;
            mismatches  = 0;
            clear_session();
        endfunction

        function void clear_session();
            foreach (target[j]) target[j] = 0;
            last_seq = '0;
            baseline = '0;
            active   = 1'b0;
        endfunction

        function void write_reg(jsi_pkg::cfg_idx_t idx,
                                logic [jsi_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                jsi_pkg::CFG_DEADBAND:    deadband    = data[jsi_pkg::MAG_W-1:0];
                jsi_pkg::CFG_SCALE:       scale       = data;
                jsi_pkg::CFG_MAX_STEP:    max_step    = data[jsi_pkg::MAG_W-1:0];
                jsi_pkg::CFG_NEGATE_MASK: negate_mask = data[jsi_pkg::MASK_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // works out the targets and flags for one accepted request
        function void note_request(logic [1:0] req, logic [jsi_pkg::SEQ_W-1:0] sseq,
                                   logic [jsi_pkg::SEQ_W-1:0] cseq, logic valid,
                                   joint_vec_t vals);
            setpoint_result_t res;
            longint inc, mag, step, lim, sum;
            res = '0;
            if (req == jsi_pkg::REQ_START) begin
                foreach (target[j]) target[j] = longint'($signed(vals[j]));
                last_seq = sseq;
                baseline = cseq;
                active   = 1'b1;
            end else if (req == jsi_pkg::REQ_CLEAR) begin
                clear_session();
            end else if (req == jsi_pkg::REQ_UPDATE && active) begin
                if (cseq > baseline) begin
                    res.flags.cmpl_edge = 1'b1;
                end else if (sseq != last_seq) begin
                    last_seq = sseq;
                    res.flags.consumed = 1'b1;
                    if (valid) begin
                        for (int j = 0; j < jsi_pkg::MAX_JOINTS; j++) begin
                            inc = longint'($signed(vals[j]));
                            mag = (inc < 0) ? -inc : inc;
                            if (mag > longint'(deadband)) begin
                                // arithmetic shift floors the Q32.32 product
                                step = (inc * longint'(scale)) >>> jsi_pkg::SHIFT;
                                if (negate_mask[j])
                                    step = -step;
                                lim = longint'(max_step);
                                if (step > lim)
                                    step = lim;
                                else if (step < -lim)
                                    step = -lim;
                                sum = target[j] + step;
                                if (sum > TARGET_MAX)
                                    sum = TARGET_MAX;
                                else if (sum < TARGET_MIN)
                                    sum = TARGET_MIN;
                                target[j] = sum;
                            end
                        end
                        res.flags.applied = 1'b1;
                    end
                end
            end
            foreach (target[j]) res.targets[j] = 32'(target[j]);
            expected_q.push_back(res);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
            end
        endfunction

        function void check_result(jsi_pkg::flags_t got_flags, joint_vec_t got_targets);
            setpoint_result_t want;
            if (expected_q.size() == 0) begin
                mismatches++;
                $display("%0t: result with nothing expected, flags %b targets %h",
                         $time, got_flags, got_targets);
                return;
            end
            want = expected_q.pop_front();
            compare_field("completion_edge", want.flags.cmpl_edge, got_flags.cmpl_edge);
            compare_field("sample_taken", want.flags.consumed, got_flags.consumed);
            compare_field("incr_applied", want.flags.applied, got_flags.applied);
            for (int j = 0; j < jsi_pkg::MAX_JOINTS; j++)
                compare_field($sformatf("target%0d", j), want.targets[j], got_targets[j]);
        endfunction
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [255:0]                   s_tdata;
    logic [2:0]                     s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [191:0]                   m_tdata;
    logic [2:0]                     m_tuser;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [jsi_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [jsi_pkg::CFG_DATA_W-1:0] cfg_data;

    setpoint_scoreboard_t sb = new();

    int unsigned   burst_left;
    int unsigned   stuck_cycles;
    int unsigned   hold_off_reqs;
    bit            gen_active;
    logic [31:0]   gen_seq;
    logic [31:0]   gen_base;

    jog_increment_setpoint_integrator_top #(
        .JOINTS (jsi_pkg::JOINTS_DEF)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(jsi_pkg::flags_t'(m_tuser), joint_vec_t'(m_tdata));
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // result side: stall pattern switches among four modes, long hold on request
    initial begin : receiver
        int unsigned cyc;
        int unsigned mode;
        int unsigned holds_served;
        cyc          = 0;
        mode         = 0;
        holds_served = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc % 64 == 0)
                mode = $urandom_range(0, 3);
            if (hold_off_reqs != holds_served) begin
                holds_served++;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= $urandom_range(0, 1);
                    2: m_tready <= (cyc % 4 != 0);
                    default: m_tready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    task automatic send_request(input logic [1:0] req, input logic [31:0] sseq,
                                input logic [31:0] cseq, input logic valid,
                                input joint_vec_t vals);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {vals, cseq, sseq};
        s_tuser  <= {valid, req};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(req, sseq, cseq, valid, vals);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input jsi_pkg::cfg_idx_t idx, input logic [31:0] data,
                             input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
        if (last)
            cfg_valid <= 1'b0;
    endtask

    task automatic write_all_regs(input logic [31:0] db, input logic [31:0] sc,
                                  input logic [31:0] ms, input logic [31:0] nm);
        cfg_write(jsi_pkg::CFG_DEADBAND, db, 1'b0);
        cfg_write(jsi_pkg::CFG_SCALE, sc, 1'b0);
        cfg_write(jsi_pkg::CFG_MAX_STEP, ms, 1'b0);
        cfg_write(jsi_pkg::CFG_NEGATE_MASK, nm, 1'b1);
    endtask

    task automatic random_config();
        logic [31:0] db, sc, ms;
        db = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'h7FFF_FFFF)
                                          : $urandom_range(0, 32'h2_0000);
        case ($urandom_range(0, 3))
            0: sc = $urandom;
            1: sc = $urandom_range(0, 32'h4_0000) - 32'h2_0000;
            2: sc = $urandom_range(1, 16);
            default: sc = -$urandom_range(1, 16);
        endcase
        ms = $urandom_range(0, 1) ? $urandom_range(0, 32'h7FFF_FFFF)
                                  : $urandom_range(0, 32'h4_0000);
        write_all_regs(db, sc, ms, $urandom_range(0, 63));
    endtask

    function automatic logic [31:0] rand_joint();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom_range(0, 32'h4_0000) - 32'h2_0000;
            4, 5: v = $urandom;
            6: begin
                case ($urandom_range(0, 5))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0;
                    3: v = 32'hFFFF_FFFF;
                    4: v = 32'h7FFF_0000;
                    default: v = 32'h8001_0000;
                endcase
            end
            7: begin
                // straddle the deadband edge
                v = {1'b0, sb.deadband} + $urandom_range(0, 2) - 1;
                if ($urandom_range(0, 1))
                    v = -v;
            end
            default: v = $urandom_range(0, 32'hFF_FFFF) - 32'h80_0000;
        endcase
        return v;
    endfunction

    function automatic joint_vec_t rand_joints();
        joint_vec_t vals;
        for (int j = 0; j < jsi_pkg::MAX_JOINTS; j++)
            vals[j] = rand_joint();
        return vals;
    endfunction

    // mostly sessions of consecutive samples, with repeats, edges and noise
    task automatic random_part(input int count);
        int unsigned pick;
        logic [31:0] sseq, cseq;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3 || (!gen_active && pick < 80)) begin
                sseq = $urandom;
                cseq = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1000);
                gen_seq    = sseq;
                gen_base   = cseq;
                gen_active = 1'b1;
                send_request(jsi_pkg::REQ_START, sseq, cseq, $urandom_range(0, 1),
                             rand_joints());
            end else if (pick < 5) begin
                gen_active = 1'b0;
                send_request(jsi_pkg::REQ_CLEAR, $urandom, $urandom, $urandom_range(0, 1),
                             rand_joints());
            end else if (pick < 6) begin
                send_request(REQ_UNUSED, $urandom, $urandom, $urandom_range(0, 1),
                             rand_joints());
            end else begin
                case ($urandom_range(0, 19))
                    0: sseq = gen_seq;
                    1: sseq = $urandom;
                    default: sseq = gen_seq + 1;
                endcase
                case ($urandom_range(0, 19))
                    0: cseq = gen_base + $urandom_range(1, 3);
                    1: cseq = $urandom;
                    default: cseq = (gen_base >= 2) ? gen_base - $urandom_range(0, 2) : gen_base;
                endcase
                gen_seq = sseq;
                send_request(jsi_pkg::REQ_UPDATE, sseq, cseq, $urandom_range(0, 9) != 0,
                             rand_joints());
            end
        end
    endtask

    // runs with the reset register values: unit gain, unit clamp
    task automatic directed_part();
        send_request(jsi_pkg::REQ_UPDATE, 32'd1, 32'd0, 1'b1, {6{32'h0001_0000}});
        send_request(REQ_UNUSED, 32'd2, 32'd0, 1'b1, {6{32'h0002_0000}});
        send_request(jsi_pkg::REQ_START, 32'd5, 32'd10, 1'b0,
                     {32'h1234_5678, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF});
        send_request(jsi_pkg::REQ_UPDATE, 32'd5, 32'd10, 1'b1, {6{32'h0001_0000}});
        send_request(jsi_pkg::REQ_UPDATE, 32'd6, 32'd11, 1'b1, {6{32'h0001_0000}});
        // saturation at both ends, clamp, unit step, zero increment
        send_request(jsi_pkg::REQ_UPDATE, 32'd6, 32'd10, 1'b1,
                     {32'd1, 32'hFFFF_FFFF, 32'd0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF});
        send_request(jsi_pkg::REQ_UPDATE, 32'd7, 32'd3, 1'b0, {6{32'h0003_0000}});
        send_request(jsi_pkg::REQ_UPDATE, 32'd8, 32'd10, 1'b1,
                     {32'hFFFF_FFFD, 32'd3, 32'hFFFF_8000, 32'h0000_8000, 32'h0001_0000,
                      32'hFFFF_0000});
        send_request(jsi_pkg::REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                     {6{32'hFFFF_FFFF}});
        send_request(jsi_pkg::REQ_UPDATE, 32'd9, 32'd0, 1'b1, {6{32'h0001_0000}});
        send_request(jsi_pkg::REQ_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                     {32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h8000_0000});
        send_request(jsi_pkg::REQ_UPDATE, 32'd0, 32'hFFFF_FFFF, 1'b1, {6{32'hFFFF_FFFF}});
        send_request(jsi_pkg::REQ_UPDATE, 32'd0, 32'd0, 1'b1, {6{32'h0001_0000}});
        send_request(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, {6{32'hFFFF_FFFF}});
        send_request(jsi_pkg::REQ_CLEAR, 32'd0, 32'd0, 1'b0, {6{32'h0}});
    endtask

    initial begin : stimulus
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= jsi_pkg::CFG_DEADBAND;
        cfg_data  <= '0;
        burst_left    = 0;
        hold_off_reqs = 0;
        gen_active    = 1'b0;
        gen_seq       = '0;
        gen_base      = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        directed_part();
        random_part(150);
        drain();

        write_all_regs(32'd0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h0);
        random_part(200);
        drain();

        // most negative gain, widest clamp, all joints reversed; output held off
        write_all_regs(32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h3F);
        hold_off_reqs++;
        random_part(200);
        drain();

        write_all_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'h2A);
        random_part(150);
        drain();

        repeat (5) begin
            random_config();
            random_part(190);
            drain();
        end

        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/jsi_pkg.sv
hw/rtl/jsi_lane.sv
hw/rtl/jsi_target.sv
hw/rtl/jsi_ctrl.sv
hw/rtl/jog_increment_setpoint_integrator_top.sv
sim/tb_top.sv
